// File: hdl/int64_to_decimal_ascii_top_macros.svh
// assertion macros for the decimal ascii formatter
// used by the checker bound to the top level; no other dependencies
`ifndef INT64_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define INT64_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// property checked only while out of reset
`define I64DA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define I64DA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/i64da_pkg.sv
// shared types and constants of the decimal ascii formatter
// no dependencies
package i64da_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CAP_W  = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CAP_W-1:0]  cap_t;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_NONE  = 8'h00;
  localparam cap_t  CAP_RESET  = 8'd24;

  // func input codes
  localparam logic FUNC_SIGNED   = 1'b0;
  localparam logic FUNC_UNSIGNED = 1'b1;

endpackage

// File: hdl/int64_to_decimal_ascii_top.sv
// decimal ascii formatter: bit-serial double dabble, then one character per cycle
// depends on i64da_pkg
//
//  channel   | direction | ports                                   | handshake
//  ----------+-----------+-----------------------------------------+------------------------
//  request   | in        | func_i, value_i                         | start_i && !busy_o
//  result    | out       | char_out_o, last_o, error_o, length_o   | strobe_o, one cycle
//  capacity  | in        | dest_capacity_i                         | dest_capacity_we_i
//
// a request holds busy_o through VALUE_BITS shifts of the bcd register, then through one skip
// step per leading zero digit dropped plus one decision step, then through one emit step per
// character, one more with a minus sign; an error request ends at the decision step, and a
// new request is taken only once busy_o has fallen.
// reset (rst_ni low) returns to idle and sets the capacity to 24.
// results cannot be stalled; busy_o falls as the last result is registered.
module int64_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              func_i,
  input  logic [63:0]       value_i,
  input  logic              dest_capacity_we_i,
  input  i64da_pkg::cap_t   dest_capacity_i,
  output logic              strobe_o,
  output i64da_pkg::char_t  char_out_o,
  output logic              last_o,
  output logic              error_o,
  output i64da_pkg::len_t   length_o
);
  import i64da_pkg::*;

  // decimal digits needed for VALUE_BITS bits
  localparam int unsigned NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W  = 4 * NDIG;
  localparam int unsigned NDIG_W = $clog2(NDIG + 1);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NDIG_W-1:0]     ndig_q, ndig_d;
  logic                  neg_q, neg_d;
  logic                  sign_q, sign_d;
  len_t                  total_q, total_d;
  len_t                  rem_q, rem_d;
  cap_t                  cap_q;
  logic                  strobe_q, strobe_d;
  char_t                 char_q, char_d;
  logic                  last_q, last_d;
  logic                  error_q, error_d;
  len_t                  length_q, length_d;

  logic [VALUE_BITS-1:0] word;
  logic                  word_neg;
  logic [3:0]            top_digit;
  len_t                  total_now;

  // input word, sign and magnitude
  assign word      = value_i[VALUE_BITS-1:0];
  assign word_neg  = (func_i == FUNC_SIGNED) && word[VALUE_BITS-1];
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign total_now = len_t'(ndig_q) + len_t'(neg_q);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < NDIG; i++) begin
      dig = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    ndig_d   = ndig_q;
    neg_d    = neg_q;
    sign_d   = sign_q;
    total_d  = total_q;
    rem_d    = rem_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    error_d  = error_q;
    length_d = length_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mag_d   = word_neg ? (~word + 1'b1) : word;
          neg_d   = word_neg;
          bcd_d   = '0;
          cnt_d   = CNT_W'(VALUE_BITS - 1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          ndig_d  = NDIG_W'(NDIG);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == 4'd0) && (ndig_q > NDIG_W'(1))) begin
          // drop one leading zero digit
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else if (cap_t'(total_now) >= cap_q) begin
          // text does not fit: one error result
          strobe_d = 1'b1;
          char_d   = CHAR_NONE;
          last_d   = 1'b1;
          error_d  = 1'b1;
          length_d = '0;
          state_d  = ST_IDLE;
        end else begin
          total_d = total_now;
          rem_d   = total_now;
          sign_d  = neg_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        error_d  = 1'b0;
        last_d   = (rem_q == len_t'(1));
        length_d = (rem_q == len_t'(1)) ? total_q : '0;
        rem_d    = rem_q - 1'b1;
        if (sign_q) begin
          char_d = CHAR_MINUS;
          sign_d = 1'b0;
        end else begin
          char_d = CHAR_ZERO + char_t'(top_digit);
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
        end
        if (rem_q == len_t'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (dest_capacity_we_i) begin
        cap_q <= dest_capacity_i;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    bcd_q    <= bcd_d;
    cnt_q    <= cnt_d;
    ndig_q   <= ndig_d;
    neg_q    <= neg_d;
    sign_q   <= sign_d;
    total_q  <= total_d;
    rem_q    <= rem_d;
    char_q   <= char_d;
    last_q   <= last_d;
    error_q  <= error_d;
    length_q <= length_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign strobe_o   = strobe_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;
  assign error_o    = error_q;
  assign length_o   = length_q;

endmodule

// File: hdl/i64da_checker.sv
// port-level checks of the decimal ascii formatter, bound to the top level
// depends on i64da_pkg and int64_to_decimal_ascii_top_macros.svh
`include "int64_to_decimal_ascii_top_macros.svh"

module i64da_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              strobe_o,
  input i64da_pkg::char_t  char_out_o,
  input logic              last_o,
  input logic              error_o,
  input i64da_pkg::len_t   length_o
);
  import i64da_pkg::*;

  logic err_ok;
  logic mid_ok;
  logic last_char;

  // shapes of the error result, a middle result and a final character
  assign err_ok    = last_o && (length_o == '0) && (char_out_o == CHAR_NONE);
  assign mid_ok    = (length_o == '0) && !error_o && busy_o;
  assign last_char = strobe_o && last_o && !error_o;

  // an accepted request keeps the block busy
  `I64DA_ASSERT(a_req_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "request not taken")

  // an error result is empty and final
  `I64DA_ASSERT(a_err_form, clk_i, rst_ni, (strobe_o && error_o) |-> err_ok, "bad error result")

  // a result that is not last carries no length and no error and the request is still busy
  `I64DA_ASSERT(a_mid_form, clk_i, rst_ni, (strobe_o && !last_o) |-> mid_ok, "bad middle result")

  // a final character result reports a nonzero count
  `I64DA_ASSERT(a_last_len, clk_i, rst_ni, last_char |-> (length_o != '0), "zero length on last")

  // nothing is delivered once reset has been seen at an edge
  `I64DA_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !strobe_o, "result during reset")

endmodule

bind int64_to_decimal_ascii_top i64da_checker u_i64da_checker (.*);
